// ----- hdl/rc6_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc6_pkg
// Types and constants shared by the RC6 block cipher modules.
// ----------------------------------------------------------------------------
package rc6_pkg;

   localparam logic [31:0] P32 = 32'hB7E15163;
   localparam logic [31:0] Q32 = 32'h9E3779B9;

   localparam logic [2:0] CSR_KEY01 = 3'd0;
   localparam logic [2:0] CSR_KEY23 = 3'd1;
   localparam logic [2:0] CSR_KEY45 = 3'd2;
   localparam logic [2:0] CSR_KEY67 = 3'd3;
   localparam logic [2:0] CSR_KLEN  = 3'd4;

   localparam logic [1:0] KLEN_16 = 2'd0;
   localparam logic [1:0] KLEN_24 = 2'd1;
   localparam logic [1:0] KLEN_32 = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [31:0] in_a;
      logic [31:0] in_b;
      logic [31:0] in_c;
      logic [31:0] in_d;
   } req_type;

   typedef struct packed {
      logic [31:0] out_a;
      logic [31:0] out_b;
      logic [31:0] out_c;
      logic [31:0] out_d;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_MIX_A,
      ST_MIX_B,
      ST_LOAD,
      ST_PRE,
      ST_RND_RD,
      ST_RND,
      ST_POST,
      ST_DONE,
      ST_WHITEN,
      ST_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_blk;
      logic init_wr;
      logic mix_a;
      logic mix_b;
      logic pre;
      logic rnd;
      logic post;
      logic clr_ab;
   } cmd_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] w;
      w = {x, x} << n;
      return w[63:32];
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] w;
      w = {x, x} >> n;
      return w[31:0];
   endfunction

endpackage

// ----- hdl/rc6_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc6_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rc6_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 44
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/rc6_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc6_datapath
// Block registers, round logic and key-schedule mixing.
// ----------------------------------------------------------------------------
module rc6_datapath (
   input  logic             clock,
   input  rc6_pkg::cmd_type cmd,
   input  rc6_pkg::req_type req,
   input  logic [31:0]      rk_rd,
   input  logic [31:0]      ks_rd,
   input  logic [31:0]      init_val,
   output logic [31:0]      rk_wr,
   output logic [31:0]      ks_wr,
   output rc6_pkg::rsp_type rsp
);
   import rc6_pkg::*;

   logic        mode_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [31:0] sa_ff, sb_ff, sa_in, sb_in;
   logic [31:0] k1_ff;
   logic [31:0] fb, fd, pb, pd, sa_new, sum_ab;
   logic [31:0] ea, ec, dc, da;

   // previous round key (the first of the pair, read in the cycle before the second)
   always_ff @(posedge clock) begin
      k1_ff <= rk_rd;
   end

   always_comb begin
      pb = b_ff * {b_ff[30:0], 1'b1};
      pd = d_ff * {d_ff[30:0], 1'b1};
      fb = rotl32(pb, 5'd5);
      fd = rotl32(pd, 5'd5);
      // encrypt: k1_ff holds S[2i], rk_rd holds S[2i+1]
      ea = rotl32(a_ff ^ fb, fd[4:0]) + k1_ff;
      ec = rotl32(c_ff ^ fd, fb[4:0]) + rk_rd;
      // decrypt on pre-rotated words: k1_ff = S[2i+1], rk_rd = S[2i]
      dc = rotr32(c_ff - k1_ff, fb[4:0]) ^ fd;
      da = rotr32(a_ff - rk_rd, fd[4:0]) ^ fb;
      sa_new = rotl32(rk_rd + sa_ff + sb_ff, 5'd3);
      // the L update already sees the new A
      sum_ab = sa_new + sb_ff;
      ks_wr  = rotl32(ks_rd + sum_ab, sum_ab[4:0]);
      rk_wr  = cmd.init_wr ? init_val : sa_new;

      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      sa_in = sa_ff; sb_in = sb_ff;
      if (cmd.clr_ab) begin
         sa_in = '0; sb_in = '0;
      end
      if (cmd.mix_a) begin
         sa_in = sa_new;
      end
      if (cmd.mix_b) begin
         sb_in = ks_wr;
      end
      if (cmd.load_blk) begin
         a_in = req.in_a; b_in = req.in_b; c_in = req.in_c; d_in = req.in_d;
      end
      if (cmd.pre) begin
         // k1_ff = S[0] / S[43], rk_rd = S[1] / S[42]
         if (!mode_ff) begin
            b_in = b_ff + k1_ff; d_in = d_ff + rk_rd;
         end else begin
            // rotate in advance for the first decrypt round
            c_in = b_ff; b_in = a_ff - rk_rd; a_in = d_ff; d_in = c_ff - k1_ff;
         end
      end
      if (cmd.rnd) begin
         if (!mode_ff) begin
            a_in = b_ff; b_in = ec; c_in = d_ff; d_in = ea;
         end else begin
            // result round, then the next round's rotation
            a_in = d_ff; b_in = da; c_in = b_ff; d_in = dc;
         end
      end
      if (cmd.post) begin
         if (!mode_ff) begin
            a_in = a_ff + k1_ff; c_in = c_ff + rk_rd;
         end else begin
            // undo the extra rotation; k1_ff = S[0], rk_rd = S[1]
            a_in = b_ff; b_in = c_ff - k1_ff; c_in = d_ff; d_in = a_ff - rk_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_blk) begin
         mode_ff <= req.mode;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      sa_ff <= sa_in; sb_ff <= sb_in;
   end

   assign rsp = '{out_a: a_ff, out_b: b_ff, out_c: c_ff, out_d: d_ff};
endmodule

// ----- hdl/rc6_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc6_control
// Sequencer for key schedule and block rounds; drives RAM addresses.
// ----------------------------------------------------------------------------
module rc6_control #(
   parameter int ROUNDS = 20,
   parameter int RKW    = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             key_dirty,
   input  logic [1:0]       klen,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             mode,
   output logic             sched_done,
   output rc6_pkg::cmd_type cmd,
   output logic [RKW-1:0]   rk_addr,
   output logic             rk_we,
   output logic [2:0]       ks_addr,
   output logic             ks_we,
   output logic [31:0]      init_val
);
   import rc6_pkg::*;

   localparam int RKN = 2 * ROUNDS + 4;
   localparam int V   = 3 * RKN;
   localparam int VW  = $clog2(V + 1);
   localparam int RW  = $clog2(ROUNDS + 1);

   state_type      state_ff, state_in;
   logic [RKW-1:0] i_ff, i_in;
   logic [2:0]     j_ff, j_in;
   logic [VW-1:0]  s_ff, s_in;
   logic [RW-1:0]  r_ff, r_in;
   logic [31:0]    iv_ff, iv_in;
   logic           m_ff, m_in;
   logic [2:0]     jmax;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in; j_ff <= j_in; s_ff <= s_in; r_ff <= r_in;
      iv_ff <= iv_in; m_ff <= m_in;
   end

   always_comb begin
      case (klen)
         KLEN_24: jmax = 3'd5;
         KLEN_32: jmax = 3'd7;
         default: jmax = 3'd3;
      endcase
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; s_in = s_ff; r_in = r_ff; iv_in = iv_ff; m_in = m_ff;
      cmd = '0;
      req_ready = 1'b0; rsp_valid = 1'b0; sched_done = 1'b0;
      rk_addr = i_ff; rk_we = 1'b0; ks_addr = j_ff; ks_we = 1'b0;
      init_val = iv_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_blk = 1'b1;
               m_in = mode;
               if (key_dirty) begin
                  state_in = ST_INIT; i_in = '0; iv_in = P32;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1; rk_we = 1'b1;
            iv_in = iv_ff + Q32;
            ks_we = 1'b1; ks_addr = i_ff[2:0];
            if (i_ff == RKW'(RKN - 1)) begin
               state_in = ST_MIX_A; i_in = '0; j_in = '0; s_in = '0; cmd.clr_ab = 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_MIX_A: begin
            // wait for S[i] and L[j] reads
            state_in = ST_MIX_B;
         end
         ST_MIX_B: begin
            cmd.mix_a = 1'b1; cmd.mix_b = 1'b1; rk_we = 1'b1;
            state_in = ST_MIX_A;
            if (s_ff == VW'(V - 1)) begin
               state_in = ST_LOAD;
               sched_done = 1'b1;
            end
            s_in = s_ff + 1'b1;
            i_in = (i_ff == RKW'(RKN - 1)) ? '0 : i_ff + 1'b1;
            j_in = (j_ff == jmax) ? '0 : j_ff + 1'b1;
         end
         ST_LOAD: begin
            rk_addr = m_ff ? RKW'(RKN - 1) : '0;
            state_in = ST_PRE;
         end
         ST_PRE: begin
            rk_addr = m_ff ? RKW'(RKN - 2) : RKW'(1);
            state_in = ST_RND_RD; r_in = RW'(1);
         end
         ST_RND_RD: begin
            // whitening or the previous round, on the two keys read in the preceding states
            if (r_ff == RW'(1)) begin
               cmd.pre = 1'b1;
            end else begin
               cmd.rnd = 1'b1;
            end
            rk_addr = m_ff ? RKW'(2 * (ROUNDS + 1 - r_ff) + 1) : RKW'(2 * r_ff);
            state_in = ST_RND;
         end
         ST_RND: begin
            rk_addr = m_ff ? RKW'(2 * (ROUNDS + 1 - r_ff)) : RKW'(2 * r_ff + 1);
            if (r_ff == RW'(ROUNDS)) begin
               state_in = ST_POST;
            end else begin
               r_in = r_ff + 1'b1; state_in = ST_RND_RD;
            end
         end
         ST_POST: begin
            cmd.rnd = 1'b1;
            rk_addr = m_ff ? '0 : RKW'(RKN - 2);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rk_addr = m_ff ? RKW'(1) : RKW'(RKN - 1);
            state_in = ST_WHITEN;
         end
         ST_WHITEN: begin
            cmd.post = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- hdl/block_cipher_128bit_rounds.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cipher_128bit_rounds
// RC6-32 block cipher with cached key schedule.
// ----------------------------------------------------------------------------
// Each round reads its two round keys through the single round-key RAM
// port; the next request is taken only once the result has left the output
// register. A key write makes the next block rebuild the schedule first
// (table init, then mixing steps of one RAM read then write each). One
// block at a time.
// Synchronous reset clears key registers and marks the schedule stale.
module block_cipher_128bit_rounds #(
   parameter int ROUNDS = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rc6_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rc6_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import rc6_pkg::*;

   localparam int RKN = 2 * ROUNDS + 4;
   localparam int RKW = $clog2(RKN);

   logic [63:0] key_ff [4];
   logic [1:0]  klen_ff;
   logic        dirty_ff;
   logic        sched_done;
   cmd_type     cmd;
   logic [RKW-1:0] rk_addr;
   logic        rk_we, ks_we;
   logic [2:0]  ks_addr;
   logic [31:0] rk_rd, ks_rd, rk_wr, ks_wr, init_val, ks_src;
   rsp_type     out_ff;
   logic        out_v_ff;
   rsp_type     dp_rsp;
   logic        c_ready, c_rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) key_ff[k] <= '0;
         klen_ff <= '0; dirty_ff <= 1'b1;
      end else begin
         if (sched_done) dirty_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_KEY01: begin key_ff[0] <= csr_wdata; dirty_ff <= 1'b1; end
               CSR_KEY23: begin key_ff[1] <= csr_wdata; dirty_ff <= 1'b1; end
               CSR_KEY45: begin key_ff[2] <= csr_wdata; dirty_ff <= 1'b1; end
               CSR_KEY67: begin key_ff[3] <= csr_wdata; dirty_ff <= 1'b1; end
               CSR_KLEN: begin
                  klen_ff <= (csr_wdata[1:0] == 2'd3) ? KLEN_16 : csr_wdata[1:0];
                  dirty_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // key words enter the scratch RAM during table init
   assign ks_src = ks_addr[0] ? key_ff[ks_addr[2:1]][63:32] : key_ff[ks_addr[2:1]][31:0];

   // no new transaction while a result is still waiting
   rc6_control #(.ROUNDS(ROUNDS), .RKW(RKW)) u_ctl (
      .clock, .reset, .key_dirty(dirty_ff), .klen(klen_ff),
      .req_valid(req_valid && !out_v_ff), .req_ready(c_ready), .rsp_valid(c_rsp_valid),
      .mode(req_data.mode), .sched_done, .cmd, .rk_addr, .rk_we, .ks_addr,
      .ks_we, .init_val
   );

   rc6_datapath u_dp (
      .clock, .cmd, .req(req_data), .rk_rd, .ks_rd, .init_val,
      .rk_wr, .ks_wr, .rsp(dp_rsp)
   );

   rc6_ram #(.WIDTH(32), .DEPTH(RKN)) u_rk (
      .clock, .wr_en(rk_we), .addr(rk_addr), .wr_data(rk_wr), .rd_data(rk_rd)
   );

   rc6_ram #(.WIDTH(32), .DEPTH(8)) u_ks (
      .clock, .wr_en(ks_we || cmd.mix_b), .addr(ks_addr),
      .wr_data(cmd.init_wr ? ks_src : ks_wr), .rd_data(ks_rd)
   );

   assign req_ready = c_ready && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         out_v_ff <= 1'b0;
      end else if (c_rsp_valid) begin
         out_v_ff <= 1'b1;
      end
      if (c_rsp_valid) out_ff <= dp_rsp;
   end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the RC6-32/20 block cipher: a local model of the key schedule and
// of block encryption and decryption predicts each result, which is compared
// word by word with the block output. Keys of all three lengths are loaded
// between phases while the block is idle; both channels idle and stall at
// varying rates.
// ----------------------------------------------------------------------------
module tb;
   import rc6_pkg::*;

   localparam int NR     = 20;
   localparam int NKEYS  = 2 * NR + 4;
   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   logic [63:0] key_reg [4];
   logic [1:0]  klen_reg;
   logic [31:0] sched [NKEYS];
   rsp_type     expected_blocks [$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   block_cipher_128bit_rounds dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] f_mix(input logic [31:0] x);
      logic [31:0] p;
      p = x * (2 * x + 32'd1);
      return {p[26:0], p[31:27]};
   endfunction

   function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
      return (x << n) | (n == 0 ? 32'd0 : x >> (6'd32 - n));
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input logic [4:0] n);
      return (x >> n) | (n == 0 ? 32'd0 : x << (6'd32 - n));
   endfunction

   task automatic expand_key();
      logic [31:0] l [8];
      logic [31:0] a, b;
      int c, i, j;
      for (i = 0; i < 8; i++) l[i] = key_reg[i / 2][(i % 2) * 32 +: 32];
      c = (klen_reg == KLEN_24) ? 6 : (klen_reg == KLEN_32) ? 8 : 4;
      sched[0] = P32;
      for (i = 1; i < NKEYS; i++) sched[i] = sched[i - 1] + Q32;
      a = 0; b = 0; i = 0; j = 0;
      for (int s = 0; s < 3 * NKEYS; s++) begin
         sched[i] = rol(sched[i] + a + b, 5'd3);
         a = sched[i];
         l[j] = rol(l[j] + a + b, 5'(a + b));
         b = l[j];
         i = (i + 1) % NKEYS;
         j = (j + 1) % c;
      end
   endtask

   function automatic rsp_type cipher_block(input req_type r);
      logic [31:0] a, b, c, d, t, u, tmp;
      a = r.in_a; b = r.in_b; c = r.in_c; d = r.in_d;
      if (r.mode == MODE_ENC) begin
         b += sched[0]; d += sched[1];
         for (int i = 1; i <= NR; i++) begin
            t = f_mix(b); u = f_mix(d);
            a = rol(a ^ t, u[4:0]) + sched[2 * i];
            c = rol(c ^ u, t[4:0]) + sched[2 * i + 1];
            tmp = a; a = b; b = c; c = d; d = tmp;
         end
         a += sched[2 * NR + 2]; c += sched[2 * NR + 3];
      end else begin
         c -= sched[2 * NR + 3]; a -= sched[2 * NR + 2];
         for (int i = NR; i >= 1; i--) begin
            tmp = d; d = c; c = b; b = a; a = tmp;
            u = f_mix(d); t = f_mix(b);
            c = ror(c - sched[2 * i + 1], t[4:0]) ^ u;
            a = ror(a - sched[2 * i], u[4:0]) ^ t;
         end
         d -= sched[1]; b -= sched[0];
      end
      return '{a, b, c, d};
   endfunction

   // block is idle: no result outstanding and room for any trailing work
   task automatic wait_idle();
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx <= CSR_KLEN) begin
         if (idx == CSR_KLEN) klen_reg = val[1:0];
         else key_reg[idx[1:0]] = val;
         expand_key();
      end
      @(posedge clock);
   endtask

   task automatic load_key(input logic [1:0] klen, input logic [63:0] k0, k1, k2, k3);
      wait_idle();
      csr_write(CSR_KEY01, k0);
      csr_write(CSR_KEY23, k1);
      csr_write(CSR_KEY45, k2);
      csr_write(CSR_KEY67, k3);
      csr_write(CSR_KLEN, 64'(klen));
   endtask

   task automatic send_block(input logic mode, input logic [31:0] a, b, c, d);
      req_type r;
      r = '{mode, a, b, c, d};
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      expected_blocks.push_back(cipher_block(r));
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_random(input int n);
      for (int k = 0; k < n; k++)
         send_block(1'($urandom), $urandom, $urandom, $urandom, $urandom);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected transaction %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_blocks.pop_front();
            if (e.out_a !== rsp_data.out_a || e.out_b !== rsp_data.out_b ||
                e.out_c !== rsp_data.out_c || e.out_d !== rsp_data.out_d) begin
               $display("%0t: mismatch expected %h actual %h", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   task automatic test_zero_key();
      // key registers all zero out of reset, schedule built on first block
      send_block(MODE_ENC, 32'h0, 32'h0, 32'h0, 32'h0);
      send_block(MODE_DEC, 32'h0, 32'h0, 32'h0, 32'h0);
      send_block(MODE_ENC, '1, '1, '1, '1);
      send_block(MODE_DEC, '1, '1, '1, '1);
      send_block(MODE_ENC, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h1);
   endtask

   task automatic test_key_lengths();
      load_key(KLEN_16, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '1, '1);
      send_block(MODE_ENC, 32'h03020100, 32'h07060504, 32'h0b0a0908, 32'h0f0e0d0c);
      send_block(MODE_DEC, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'h0, '1);
      load_key(KLEN_24, '1, '1, '1, 64'h0);
      send_block(MODE_ENC, '1, 32'h0, '1, 32'h0);
      send_block(MODE_DEC, 32'h0, '1, 32'h0, '1);
      load_key(KLEN_32, '1, '1, '1, '1);
      send_block(MODE_ENC, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321);
      send_block(MODE_DEC, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321);
      // length code 3 behaves as a 16-byte key
      load_key(2'd3, 64'h0123456789abcdef, 64'hfedcba9876543210, rnd64(), rnd64());
      send_block(MODE_ENC, 32'h1, 32'h2, 32'h3, 32'h4);
      send_block(MODE_DEC, 32'h1, 32'h2, 32'h3, 32'h4);
      // out-of-range index is ignored; same-value rewrite rebuilds the table
      wait_idle();
      csr_write(3'd7, '1);
      csr_write(CSR_KEY01, 64'h0123456789abcdef);
      send_block(MODE_ENC, 32'h1, 32'h2, 32'h3, 32'h4);
   endtask

   task automatic test_random_phases();
      int send_pct [4] = '{0, 86, 0, 13};
      int recv_pct [4] = '{0, 0, 86, 13};
      for (int p = 0; p < 4; p++) begin
         for (int k = 0; k < 3; k++) begin
            load_key(2'($urandom_range(3)), rnd64(), rnd64(), rnd64(), rnd64());
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            send_random(32);
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
      end
      send_random(10);
   endtask

   initial begin
      klen_reg = '0;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      expand_key();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_key();
      test_key_lengths();
      test_random_phases();
      wait_idle();
      repeat (2 * NKEYS) @(posedge clock);
      if (errors == 0 && expected_blocks.size() == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule
